### rtl/obo_pkg.sv
// ----------------------------------------------------------------------------
// obo_pkg
// Shared constants, types and helpers for the oriented box overlap test.
// ----------------------------------------------------------------------------
package obo_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PROD_W    = 2 * WORD_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int SPR_W     = WORD_W + 2;
    localparam int CHK_W     = ((WORD_W > FRAC_BITS + 1) ? WORD_W : FRAC_BITS + 1) + 3;
    localparam int EXT_W     = (WORD_W > IN_W) ? WORD_W : IN_W;

    localparam logic [1:0] M_T1 = 2'd0;
    localparam logic [1:0] M_I1 = 2'd1;
    localparam logic [1:0] M_T2 = 2'd2;
    localparam logic [1:0] M_I2 = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       first_k;
        logic       last_k;
        logic [1:0] col;
        logic       fin;
    } t_tag;

    function automatic logic signed [WORD_W-1:0] sat_entry(input logic signed [IN_W-1:0] v);
        logic signed [EXT_W-1:0]  x;
        logic signed [EXT_W-1:0]  hi;
        logic signed [EXT_W-1:0]  lo;
        logic signed [WORD_W-1:0] res;
        x  = EXT_W'(v);
        hi = EXT_W'({1'b0, {(WORD_W-1){1'b1}}});
        lo = ~hi;
        if (x > hi) begin
            res = WORD_W'(hi);
        end else if (x < lo) begin
            res = WORD_W'(lo);
        end else begin
            res = WORD_W'(x);
        end
        return res;
    endfunction

endpackage

### rtl/oriented_box_overlap_test.sv
// ----------------------------------------------------------------------------
// oriented_box_overlap_test
// Top level: entry loading front, product and test back, shared matrix store.
// ----------------------------------------------------------------------------
// Each entry item is written to a 64-entry store (address = matrix*16 +
// row*4 + column). An item with tlast then starts the test: rows 0..2 of
// both products are formed by one multiplier, one entry pair per cycle, and
// the result appears once the last pair has passed the pipeline; input is
// held off until the test is done. The store needs all four matrices
// loaded before a test.
module oriented_box_overlap_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // which_matrix[1:0], row_index[3:2],
                                        // column_index[5:4], entry_value[37:6]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // overlap[0]
);

    logic cmd_valid, cmd_pop, busy, we;
    logic [obo_pkg::ADDR_W-1:0] waddr, raddr_a, raddr_b;
    logic [obo_pkg::WORD_W-1:0] wdata, rdata_a, rdata_b;

    obo_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .i_back_busy(busy), .i_cmd_pop(cmd_pop), .o_cmd_valid(cmd_valid),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata)
    );

    obo_ram #(.WIDTH(obo_pkg::WORD_W), .DEPTH(obo_pkg::DEPTH)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(raddr_a), .i_raddr_b(raddr_b),
        .o_rdata_a(rdata_a), .o_rdata_b(rdata_b)
    );

    obo_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop), .o_busy(busy),
        .o_raddr_a(raddr_a), .o_raddr_b(raddr_b),
        .i_rdata_a(rdata_a), .i_rdata_b(rdata_b),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

endmodule

### rtl/obo_ram.sv
// ----------------------------------------------------------------------------
// obo_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module obo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/obo_front.sv
// ----------------------------------------------------------------------------
// obo_front
// Accepts entry items, saturates and stores them, queues a test request on last.
// ----------------------------------------------------------------------------
module obo_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [39:0]                 s_axis_tdata,
    input  logic                        s_axis_tlast,
    input  logic                        i_back_busy,
    input  logic                        i_cmd_pop,
    output logic                        o_cmd_valid,
    output logic                        o_we,
    output logic [obo_pkg::ADDR_W-1:0]  o_waddr,
    output logic [obo_pkg::WORD_W-1:0]  o_wdata
);

    logic r_pend;
    logic n_pend;
    logic accept;

    assign s_axis_tready = !r_pend && !i_back_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = r_pend;
    assign o_we          = accept;
    // store address is matrix*16 + row*4 + column
    assign o_waddr       = {s_axis_tdata[1:0], s_axis_tdata[3:2], s_axis_tdata[5:4]};
    assign o_wdata       = obo_pkg::sat_entry($signed(s_axis_tdata[37:6]));

    always_comb begin
        n_pend = r_pend;
        if (i_cmd_pop) begin
            n_pend = 1'b0;
        end
        if (accept && s_axis_tlast) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

endmodule

### rtl/obo_back.sv
// ----------------------------------------------------------------------------
// obo_back
// Forms rows 0..2 of both products with one shared multiplier and tests the
// corner extremes of each row for separation.
// ----------------------------------------------------------------------------
module obo_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_pop,
    output logic                              o_busy,
    output logic [obo_pkg::ADDR_W-1:0]        o_raddr_a,
    output logic [obo_pkg::ADDR_W-1:0]        o_raddr_b,
    input  logic [obo_pkg::WORD_W-1:0]        i_rdata_a,
    input  logic [obo_pkg::WORD_W-1:0]        i_rdata_b,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata
);

    localparam int AW = obo_pkg::ACC_W;
    localparam int CW = obo_pkg::CHK_W;
    localparam logic signed [AW-1:0] SAT_HI = AW'({1'b0, {(obo_pkg::WORD_W-1){1'b1}}});
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [CW-1:0] ONE    = CW'(1) << obo_pkg::FRAC_BITS;

    logic r_run, r_issue, r_pass, r_sep, r_out_valid, r_overlap;
    logic [1:0] r_row, r_col, r_k;
    obo_pkg::t_tag r_t1, r_t2, r_t3, r_t4, r_t5, t0;
    logic signed [obo_pkg::PROD_W-1:0] r_prod;
    logic signed [AW-1:0] r_acc, sh;
    logic signed [obo_pkg::WORD_W-1:0] r_e, r_e3;
    logic signed [obo_pkg::SPR_W-1:0] r_spread, abs_e, ext_e;
    logic signed [CW-1:0] lo, hi;
    logic start, sep_now, done;
    logic [1:0] ma, mb;

    assign start     = i_cmd_valid && !r_run && !r_out_valid;
    assign o_cmd_pop = start;
    assign o_busy    = r_run;
    assign ma        = r_pass ? obo_pkg::M_T1 : obo_pkg::M_T2;
    assign mb        = r_pass ? obo_pkg::M_I2 : obo_pkg::M_I1;
    assign o_raddr_a = {ma, r_row, r_k};
    assign o_raddr_b = {mb, r_k, r_col};

    assign t0.valid   = r_issue;
    assign t0.first_k = (r_k == 2'd0);
    assign t0.last_k  = (r_k == 2'd3);
    assign t0.col     = r_col;
    assign t0.fin     = r_pass && (r_row == 2'd2) && (r_col == 2'd3) && (r_k == 2'd3);

    assign sh    = r_acc >>> obo_pkg::FRAC_BITS;
    assign ext_e = obo_pkg::SPR_W'(r_e);
    assign abs_e = ext_e[obo_pkg::SPR_W-1] ? -ext_e : ext_e;
    assign lo    = CW'(r_e3) - CW'(r_spread);
    assign hi    = CW'(r_e3) + CW'(r_spread);
    assign sep_now = r_t5.valid && (r_t5.col == 2'd3) && ((lo >= ONE) || (hi <= -ONE));
    assign done  = r_t5.valid && r_t5.fin;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_overlap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_issue <= 1'b0;
            r_out_valid <= 1'b0;
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
            r_t5 <= '0;
            r_pass <= 1'b0;
            r_row <= 2'd0;
            r_col <= 2'd0;
            r_k <= 2'd0;
            r_sep <= 1'b0;
        end else begin
            r_t1 <= t0;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3.last_k ? r_t3 : '0;
            r_t5 <= r_t4;
            if (start) begin
                r_run <= 1'b1;
                r_issue <= 1'b1;
                r_pass <= 1'b0;
                r_row <= 2'd0;
                r_col <= 2'd0;
                r_k <= 2'd0;
                r_sep <= 1'b0;
            end else if (r_issue) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_col <= r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        if (r_row == 2'd2) begin
                            r_row <= 2'd0;
                            r_pass <= 1'b1;
                            if (r_pass) begin
                                r_issue <= 1'b0;
                            end
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end
                end
            end
            if (sep_now) begin
                r_sep <= 1'b1;
            end
            if (done) begin
                r_run <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= obo_pkg::PROD_W'($signed(i_rdata_a)) * obo_pkg::PROD_W'($signed(i_rdata_b));
        if (r_t2.valid) begin
            r_acc <= r_t2.first_k ? AW'(r_prod) : r_acc + AW'(r_prod);
        end
        if (r_t3.valid && r_t3.last_k) begin
            if (sh > SAT_HI) begin
                r_e <= obo_pkg::WORD_W'(SAT_HI);
            end else if (sh < SAT_LO) begin
                r_e <= obo_pkg::WORD_W'(SAT_LO);
            end else begin
                r_e <= obo_pkg::WORD_W'(sh);
            end
        end
        if (r_t4.valid) begin
            if (r_t4.col == 2'd3) begin
                r_e3 <= r_e;
            end else if (r_t4.col == 2'd0) begin
                r_spread <= abs_e;
            end else begin
                r_spread <= r_spread + abs_e;
            end
        end
        if (done) begin
            r_overlap <= !(r_sep || sep_now);
        end
    end

    a_no_run_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_run && r_out_valid)) else $error("back running while result pending");
    a_pipe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t1.valid |-> r_run) else $error("pipeline active outside a test");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (!r_run && r_out_valid)) else $error("test end not reported");

endmodule

### verif/tb_oriented_box_overlap_test.sv
// ----------------------------------------------------------------------------
// tb_oriented_box_overlap_test
// Loads full matrix sets through the entry stream, with some lone entry
// rewrites in between. The overlap flag from the block is checked against a
// fixed-point model of both box products.
// ----------------------------------------------------------------------------
module tb_oriented_box_overlap_test;
    timeunit 1ns;
    timeprecision 1ps;

    class overlap_scoreboard;
        logic signed [31:0] mstore [64];
        bit                 flags [$];
        int                 n_err;
        int                 n_chk;

        function logic signed [35:0] row_term(int ma, int mb, int r, int c);
            logic signed [65:0] acc;
            logic signed [65:0] sh;
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                acc = acc + 66'(mstore[ma*16 + r*4 + k]) * 66'(mstore[mb*16 + k*4 + c]);
            end
            sh = acc >>> obo_pkg::FRAC_BITS;
            if (sh > 66'sd2147483647) sh = 66'sd2147483647;
            if (sh < -66'sd2147483648) sh = -66'sd2147483648;
            return 36'(sh);
        endfunction

        function bit boxes_apart(int ma, int mb);
            logic signed [35:0] e [4];
            logic signed [35:0] spread;
            logic signed [35:0] one;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) e[c] = row_term(ma, mb, r, c);
                spread = 0;
                for (int c = 0; c < 3; c++) spread = spread + ((e[c] < 0) ? -e[c] : e[c]);
                one = 36'sd1 <<< obo_pkg::FRAC_BITS;
                if (e[3] - spread >= one) return 1;
                if (e[3] + spread <= -one) return 1;
            end
            return 0;
        endfunction

        function void note_entry(logic [1:0] m, logic [1:0] r, logic [1:0] c,
                                 logic [31:0] v, bit lst);
            mstore[{m, r, c}] = v;
            if (lst) flags.push_back(!(boxes_apart(obo_pkg::M_T2, obo_pkg::M_I1) ||
                                       boxes_apart(obo_pkg::M_T1, obo_pkg::M_I2)));
        endfunction

        function void check_flag(bit got);
            bit want;
            n_chk++;
            if (flags.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result overlap=%0d", got);
                return;
            end
            want = flags.pop_front();
            if (want !== got) begin
                n_err++;
                if (n_err <= 10) $display("mismatch: expected %0d actual %0d", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // which[1:0], row[3:2], col[5:4], value[37:6]
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;       // overlap[0]

    overlap_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 0;
    int  n_sent = 0;

    oriented_box_overlap_test uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb_oriented_box_overlap_test failed");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_flag(m_axis_tdata[0]);
    end

    always @(negedge i_clk) m_axis_tready <= calm || ($urandom_range(99) >= 10);

    // valid stays up after an accepted item; the next call or the caller drops it
    task automatic send_entry(logic [1:0] m, logic [1:0] r, logic [1:0] c,
                              logic [31:0] v, bit lst);
        while (!calm && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {2'b00, v, c, r, m};
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_entry(m, r, c, v, lst);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0001_0000;
            3: return 32'hffff_0000;
            4: return 32'h0000_0000;
            5: return $urandom;
            default: return 32'($signed($urandom_range(6 << 16))) - (3 << 16);
        endcase
    endfunction

    // full load of all 64 entries; mode picks value style
    task automatic load_set(int mode, bit lst);
        int m;
        int e;
        for (m = 0; m < 4; m++) begin
            for (e = 0; e < 16; e++) begin
                logic [31:0] v;
                v = (mode < 0) ? pick_value($urandom_range(6)) :
                    (mode == 9) ? ((e % 5 == 0) ? 32'h0001_0000 : 32'h0) : pick_value(mode);
                send_entry(2'(m), 2'(e / 4), 2'(e % 4), v, lst && m == 3 && e == 15);
            end
        end
    endtask

    initial begin
        int k;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        load_set(9, 1);          // identity boxes overlap
        load_set(0, 1);          // saturating products
        load_set(1, 1);
        calm = 1;
        for (k = 0; k < 8; k++) begin
            load_set(-1, 0);
            send_entry(2'($urandom), 2'($urandom), 2'($urandom), pick_value(6), 1'b1);
        end
        calm = 0;
        while (n_sent < 1850) begin
            if ($urandom_range(3) == 0)
                send_entry(2'($urandom), 2'($urandom), 2'($urandom),
                           pick_value($urandom_range(6)), 1'($urandom_range(1)));
            else
                load_set(($urandom_range(4) == 0) ? 5 : 6, 1);
        end
        s_axis_tvalid <= 0;
        k = 0;
        while (sb.flags.size() != 0 && k < 100000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (200) @(posedge i_clk);
        $display("sent %0d entries, checked %0d overlap results", n_sent, sb.n_chk);
        if (sb.n_err == 0 && sb.flags.size() == 0)
            $display("tb_oriented_box_overlap_test passed");
        else
            $display("tb_oriented_box_overlap_test failed");
        $finish;
    end
endmodule
